/* rtl/core/periodic_box_wrap_min_image_macros.svh */
// Assertion macros for the periodic box wrap block.
// Used by the top level only; no other dependencies.
`ifndef PERIODIC_BOX_WRAP_MIN_IMAGE_MACROS_SVH
`define PERIODIC_BOX_WRAP_MIN_IMAGE_MACROS_SVH
`ifndef SYNTHESIS
`define PBW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbw assertion failed");
`define PBW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbw assertion failed");
`else
`define PBW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PBW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/pbw_pkg.sv */
// Shared widths, stage types and helper functions for the periodic box wrap block.
// No dependencies.
package pbw_pkg;
    localparam int CW = 32;          // coordinate width
    localparam int XW = CW + 2;      // internal position width
    localparam int MW = CW + 1;      // distance past face, unsigned
    localparam int NS = MW + 1;      // front stage plus one stage per remainder bit
    localparam int IW = 3;           // register index width

    localparam logic [IW-1:0] REG_LOWER_X  = 3'd0;
    localparam logic [IW-1:0] REG_UPPER_X  = 3'd1;
    localparam logic [IW-1:0] REG_LOWER_Y  = 3'd2;
    localparam logic [IW-1:0] REG_UPPER_Y  = 3'd3;
    localparam logic [IW-1:0] REG_LOWER_Z  = 3'd4;
    localparam logic [IW-1:0] REG_UPPER_Z  = 3'd5;
    localparam logic [IW-1:0] REG_PERIODIC = 3'd6;

    localparam logic OP_WRAP = 1'b0;

    typedef enum logic [1:0] {KIND_KEEP, KIND_DIRECT, KIND_BELOW, KIND_ABOVE} pbw_kind_t;

    typedef struct packed {
        logic signed [CW-1:0] lo;
        logic signed [CW-1:0] hi;
        logic                 periodic;
    } pbw_axis_cfg_t;

    typedef struct packed {
        logic                 op;
        logic signed [CW-1:0] disp;
        logic signed [CW-1:0] base;
        logic signed [CW-1:0] partner;
    } pbw_lane_in_t;

    typedef struct packed {
        logic signed [CW-1:0] new_disp;
        logic                 shifted;
    } pbw_lane_out_t;

    typedef struct packed {
        logic [NS-1:0] en;
    } pbw_stage_ctl_t;

    typedef struct packed {
        pbw_kind_t            kind;
        logic signed [XW-1:0] xm;
        logic signed [CW-1:0] base;
        logic signed [CW-1:0] disp;
        logic [MW-1:0]        mag;
        logic [CW-1:0]        rem;
    } pbw_stage_t;

    // one restoring step of mag mod edge
    function automatic pbw_stage_t div_step(pbw_stage_t s, logic [CW-1:0] edge_u);
        pbw_stage_t r;
        logic [CW:0] t;
        r = s;
        t = {s.rem, s.mag[MW-1]};
        if (t >= {1'b0, edge_u})
        begin
            t = t - {1'b0, edge_u};
        end
        r.rem = t[CW-1:0];
        r.mag = {s.mag[MW-2:0], 1'b0};
        return r;
    endfunction

    function automatic logic signed [CW-1:0] sat(logic signed [XW:0] v);
        logic signed [XW:0] hi_lim;
        logic signed [XW:0] lo_lim;
        hi_lim = (XW+1)'(1) <<< (CW - 1);
        hi_lim = hi_lim - 1;
        lo_lim = -hi_lim - 1;
        if (v > hi_lim)
        begin
            return {1'b0, {(CW-1){1'b1}}};
        end
        if (v < lo_lim)
        begin
            return {1'b1, {(CW-1){1'b0}}};
        end
        return v[CW-1:0];
    endfunction
endpackage

/* rtl/core/pbw_if.sv */
// Channel interfaces for the periodic box wrap block: items, results, register writes.
// Depends on pbw_pkg.
interface pbw_item_if;
    import pbw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic signed [CW-1:0] disp_x;
    logic signed [CW-1:0] disp_y;
    logic signed [CW-1:0] disp_z;
    logic signed [CW-1:0] base_x;
    logic signed [CW-1:0] base_y;
    logic signed [CW-1:0] base_z;
    logic signed [CW-1:0] partner_x;
    logic signed [CW-1:0] partner_y;
    logic signed [CW-1:0] partner_z;
    modport source (output valid, op, disp_x, disp_y, disp_z, base_x, base_y, base_z,
                    partner_x, partner_y, partner_z, input ready);
    modport sink (input valid, op, disp_x, disp_y, disp_z, base_x, base_y, base_z,
                  partner_x, partner_y, partner_z, output ready);
endinterface

interface pbw_result_if;
    import pbw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] new_disp_x;
    logic signed [CW-1:0] new_disp_y;
    logic signed [CW-1:0] new_disp_z;
    logic [2:0]           shifted_mask;
    logic                 any_shifted;
    modport source (output valid, new_disp_x, new_disp_y, new_disp_z, shifted_mask,
                    any_shifted, input ready);
    modport sink (input valid, new_disp_x, new_disp_y, new_disp_z, shifted_mask,
                  any_shifted, output ready);
endinterface

interface pbw_cfg_if;
    import pbw_pkg::*;
    logic          valid;
    logic          ready;
    logic [IW-1:0] index;
    logic [CW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/pbw_lane.sv */
// One axis lane: front decode, pipelined remainder by box edge, final correction.
// Depends on pbw_pkg.
module pbw_lane (
    input  logic                    clk,
    input  pbw_pkg::pbw_axis_cfg_t  cfg,
    input  pbw_pkg::pbw_stage_ctl_t ctl,
    input  pbw_pkg::pbw_lane_in_t   din,
    output pbw_pkg::pbw_lane_out_t  dout
);
    import pbw_pkg::*;

    logic signed [XW-1:0] lo_e;
    logic signed [XW-1:0] hi_e;
    logic signed [XW-1:0] edge_w;
    logic [CW-1:0]        edge_u;
    logic                 active;
    logic signed [XW-1:0] xs;
    logic signed [XW:0]   diff;
    logic signed [XW+1:0] twice;
    logic signed [XW+1:0] edge_ext;
    logic signed [XW-1:0] mag_below;
    logic signed [XW-1:0] mag_above;
    pbw_stage_t           front;
    pbw_stage_t           stage_reg [NS];
    pbw_stage_t           last;
    logic [CW-1:0]        adj;
    logic signed [XW-1:0] xf;
    logic signed [XW:0]   nd;

    always_comb
    begin
        lo_e      = XW'(cfg.lo);
        hi_e      = XW'(cfg.hi);
        edge_w    = hi_e - lo_e;
        edge_u    = edge_w[CW-1:0];
        active    = cfg.periodic && (edge_w > 0);
        xs        = XW'(din.base) + XW'(din.disp);
        diff      = (XW+1)'(xs) - (XW+1)'(din.partner);
        twice     = {diff, 1'b0};
        edge_ext  = (XW+2)'(edge_w);
        mag_below = lo_e - xs;
        mag_above = xs - hi_e;

        front      = '0;
        front.base = din.base;
        front.disp = din.disp;
        front.kind = KIND_KEEP;
        front.xm   = xs;
        if (active)
        begin
            if (din.op == OP_WRAP)
            begin
                if (xs < lo_e)
                begin
                    front.kind = KIND_BELOW;
                    front.mag  = mag_below[MW-1:0];
                end
                else if (xs > hi_e)
                begin
                    front.kind = KIND_ABOVE;
                    front.mag  = mag_above[MW-1:0];
                end
            end
            else
            begin
                if (twice < -edge_ext)
                begin
                    front.kind = KIND_DIRECT;
                    front.xm   = xs + edge_w;
                end
                else if (twice > edge_ext)
                begin
                    front.kind = KIND_DIRECT;
                    front.xm   = xs - edge_w;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            stage_reg[0] <= front;
        end
        for (int j = 1; j < NS; j++)
        begin
            if (ctl.en[j])
            begin
                stage_reg[j] <= div_step(stage_reg[j-1], edge_u);
            end
        end
    end

    // wrapped position lands edge - rem inside the face, or on it when rem is zero
    always_comb
    begin
        last = stage_reg[NS-1];
        adj  = (last.rem == '0) ? '0 : (edge_u - last.rem);
        case (last.kind)
            KIND_BELOW: xf = lo_e + XW'(adj);
            KIND_ABOVE: xf = hi_e - XW'(adj);
            default:    xf = last.xm;
        endcase
        nd = (XW+1)'(xf) - (XW+1)'(last.base);
        dout.shifted  = (last.kind != KIND_KEEP);
        dout.new_disp = dout.shifted ? sat(nd) : last.disp;
    end
endmodule

/* rtl/core/periodic_box_wrap_min_image.sv */
// Pipeline: front stage, 33 remainder stages and output register from item transaction
// to result valid; the remainder pipeline one bit per stage sets the depth.
// Throughput: one item per cycle; bubbles collapse and the pipeline stalls only when
// the output register is full and not taken.
// Reset: asynchronous, active low; clears stage valids, output valid and the box
// registers to the unit box with no periodic axis.
// Depends on pbw_pkg, pbw_if, pbw_lane and the macros header.
`include "periodic_box_wrap_min_image_macros.svh"
module periodic_box_wrap_min_image (
    input logic clk,
    input logic rst_n,
    pbw_item_if.sink     item,
    pbw_result_if.source result,
    pbw_cfg_if.sink      cfg
);
    import pbw_pkg::*;

    logic signed [CW-1:0] lower_reg [3];
    logic signed [CW-1:0] upper_reg [3];
    logic [2:0]           periodic_reg;
    logic [NS-1:0]        valid_reg;
    logic [NS-1:0]        free;
    logic                 out_free;
    logic                 out_valid_reg;
    pbw_stage_ctl_t       ctl;
    pbw_axis_cfg_t        axis_cfg [3];
    pbw_lane_in_t         lane_in [3];
    pbw_lane_out_t        lane_out [3];
    logic signed [CW-1:0] disp_x_reg, disp_y_reg, disp_z_reg;
    logic [2:0]           mask_reg;
    logic [2:0]           mask_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lower_reg[a] <= '0;
                upper_reg[a] <= CW'(65536);
            end
            periodic_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LOWER_X:  lower_reg[0] <= cfg.data;
                REG_UPPER_X:  upper_reg[0] <= cfg.data;
                REG_LOWER_Y:  lower_reg[1] <= cfg.data;
                REG_UPPER_Y:  upper_reg[1] <= cfg.data;
                REG_LOWER_Z:  lower_reg[2] <= cfg.data;
                REG_UPPER_Z:  upper_reg[2] <= cfg.data;
                REG_PERIODIC: periodic_reg <= cfg.data[2:0];
                default:      ;
            endcase
        end
    end

    // a stage may load when it is empty or its content moves on
    always_comb
    begin
        out_free = !out_valid_reg || result.ready;
        free[NS-1] = !valid_reg[NS-1] || out_free;
        for (int i = NS - 2; i >= 0; i--)
        begin
            free[i] = !valid_reg[i] || free[i+1];
        end
        ctl.en = free;
    end

    assign item.ready = free[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (free[0])
            begin
                valid_reg[0] <= item.valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (free[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
            if (out_free)
            begin
                out_valid_reg <= valid_reg[NS-1];
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            axis_cfg[a].lo       = lower_reg[a];
            axis_cfg[a].hi       = upper_reg[a];
            axis_cfg[a].periodic = periodic_reg[a];
            lane_in[a].op        = item.op;
        end
        lane_in[0].disp    = item.disp_x;
        lane_in[0].base    = item.base_x;
        lane_in[0].partner = item.partner_x;
        lane_in[1].disp    = item.disp_y;
        lane_in[1].base    = item.base_y;
        lane_in[1].partner = item.partner_y;
        lane_in[2].disp    = item.disp_z;
        lane_in[2].base    = item.base_z;
        lane_in[2].partner = item.partner_z;
    end

    pbw_lane u_lane_x (.clk(clk), .cfg(axis_cfg[0]), .ctl(ctl), .din(lane_in[0]),
                       .dout(lane_out[0]));
    pbw_lane u_lane_y (.clk(clk), .cfg(axis_cfg[1]), .ctl(ctl), .din(lane_in[1]),
                       .dout(lane_out[1]));
    pbw_lane u_lane_z (.clk(clk), .cfg(axis_cfg[2]), .ctl(ctl), .din(lane_in[2]),
                       .dout(lane_out[2]));

    assign mask_next = {lane_out[2].shifted, lane_out[1].shifted, lane_out[0].shifted};

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            disp_x_reg <= lane_out[0].new_disp;
            disp_y_reg <= lane_out[1].new_disp;
            disp_z_reg <= lane_out[2].new_disp;
            mask_reg   <= mask_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.new_disp_x   = disp_x_reg;
    assign result.new_disp_y   = disp_y_reg;
    assign result.new_disp_z   = disp_z_reg;
    assign result.shifted_mask = mask_reg;
    assign result.any_shifted  = (mask_reg != 3'd0);

    `PBW_ASSERT_IMPL(a_no_shift_nonperiodic, clk, rst_n, result.valid && (periodic_reg == 3'd0), result.shifted_mask == 3'd0)
    `PBW_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid_reg && !result.ready, out_valid_reg && $stable(mask_reg))
    `PBW_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, valid_reg == '0, item.ready)
endmodule

/* tb/sv/tb_periodic_box_wrap_min_image.sv */
// Self-checking bench for periodic_box_wrap_min_image: a queue-fed driver, a monitor that
// predicts each result from its own copy of the box registers, random idling on both sides.
// Depends on pbw_pkg, pbw_if and the block itself.
`timescale 1ns / 100ps
module tb_periodic_box_wrap_min_image;
    import pbw_pkg::*;

    typedef struct packed {
        logic                 op;
        logic [2:0][CW-1:0]   disp;
        logic [2:0][CW-1:0]   base;
        logic [2:0][CW-1:0]   partner;
    } pos_item_t;

    typedef struct packed {
        logic [2:0][CW-1:0]   new_disp;
        logic [2:0]           shifted_mask;
        logic                 any_shifted;
    } wrap_result_t;

    localparam longint C_MAX = 64'sd2147483647;
    localparam longint C_MIN = -64'sd2147483648;

    logic clk;
    logic rst_n;

    pbw_item_if   item_ch();
    pbw_result_if res_ch();
    pbw_cfg_if    cfg_ch();

    periodic_box_wrap_min_image dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    pos_item_t    pending_items[$];
    wrap_result_t expected_results[$];

    // box copy used for prediction, updated on each register transaction
    longint   box_lo[3];
    longint   box_hi[3];
    bit [2:0] periodic;

    bit item_taken;
    bit cfg_taken;
    bit calm;
    int mismatches;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic longint clamp_coord(longint v);
        if (v > C_MAX)
        begin
            return C_MAX;
        end
        if (v < C_MIN)
        begin
            return C_MIN;
        end
        return v;
    endfunction

    function automatic longint round_up_to_edge(longint mag, longint e);
        longint m;
        m = (mag / e) * e;
        if (m < mag)
        begin
            m = m + e;
        end
        return m;
    endfunction

    function automatic wrap_result_t predict_wrap(pos_item_t it);
        wrap_result_t r;
        longint d;
        longint b;
        longint p;
        longint x;
        longint e;
        longint twice;
        bit     moved;
        r = '0;
        for (int a = 0; a < 3; a++)
        begin
            d = longint'($signed(it.disp[a]));
            b = longint'($signed(it.base[a]));
            p = longint'($signed(it.partner[a]));
            x = b + d;
            e = box_hi[a] - box_lo[a];
            moved = 1'b0;
            if (periodic[a] && e > 0)
            begin
                if (it.op == OP_WRAP)
                begin
                    if (x < box_lo[a])
                    begin
                        x = x + round_up_to_edge(box_lo[a] - x, e);
                        moved = 1'b1;
                    end
                    else if (x > box_hi[a])
                    begin
                        x = x - round_up_to_edge(x - box_hi[a], e);
                        moved = 1'b1;
                    end
                end
                else
                begin
                    twice = 2 * (x - p);
                    if (twice < -e)
                    begin
                        x = x + e;
                        moved = 1'b1;
                    end
                    else if (twice > e)
                    begin
                        x = x - e;
                        moved = 1'b1;
                    end
                end
            end
            r.new_disp[a] = CW'(clamp_coord(moved ? x - b : d));
            r.shifted_mask[a] = moved;
        end
        r.any_shifted = |r.shifted_mask;
        return r;
    endfunction

    // monitor: everything sampled at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_taken <= 1'b0;
            cfg_taken  <= 1'b0;
        end
        else
        begin
            item_taken <= item_ch.valid && item_ch.ready;
            cfg_taken  <= cfg_ch.valid && cfg_ch.ready;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_LOWER_X:  box_lo[0] = longint'($signed(cfg_ch.data));
                    REG_UPPER_X:  box_hi[0] = longint'($signed(cfg_ch.data));
                    REG_LOWER_Y:  box_lo[1] = longint'($signed(cfg_ch.data));
                    REG_UPPER_Y:  box_hi[1] = longint'($signed(cfg_ch.data));
                    REG_LOWER_Z:  box_lo[2] = longint'($signed(cfg_ch.data));
                    REG_UPPER_Z:  box_hi[2] = longint'($signed(cfg_ch.data));
                    REG_PERIODIC: periodic  = cfg_ch.data[2:0];
                    default: ;
                endcase
            end
            if (item_ch.valid && item_ch.ready)
            begin
                expected_results.push_back(predict_wrap({item_ch.op,
                    item_ch.disp_z, item_ch.disp_y, item_ch.disp_x,
                    item_ch.base_z, item_ch.base_y, item_ch.base_x,
                    item_ch.partner_z, item_ch.partner_y, item_ch.partner_x}));
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result transaction with nothing expected");
                    end
                end
                else
                begin
                    wrap_result_t want;
                    wrap_result_t got;
                    want = expected_results.pop_front();
                    got = {res_ch.new_disp_z, res_ch.new_disp_y, res_ch.new_disp_x,
                           res_ch.shifted_mask, res_ch.any_shifted};
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch disp x/y/z exp %0d %0d %0d got %0d %0d %0d",
                                     $signed(want.new_disp[0]), $signed(want.new_disp[1]),
                                     $signed(want.new_disp[2]), $signed(got.new_disp[0]),
                                     $signed(got.new_disp[1]), $signed(got.new_disp[2]));
                            $display("  mask exp %b/%b got %b/%b", want.shifted_mask,
                                     want.any_shifted, got.shifted_mask, got.any_shifted);
                        end
                    end
                end
            end
        end
    end

    // driver: inputs change at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            res_ch.ready <= calm || ($urandom_range(99) >= 16);
            if (!item_ch.valid || item_taken)
            begin
                if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 16))
                begin
                    pos_item_t it;
                    it = pending_items.pop_front();
                    item_ch.valid     <= 1'b1;
                    item_ch.op        <= it.op;
                    item_ch.disp_x    <= it.disp[0];
                    item_ch.disp_y    <= it.disp[1];
                    item_ch.disp_z    <= it.disp[2];
                    item_ch.base_x    <= it.base[0];
                    item_ch.base_y    <= it.base[1];
                    item_ch.base_z    <= it.base[2];
                    item_ch.partner_x <= it.partner[0];
                    item_ch.partner_y <= it.partner[1];
                    item_ch.partner_z <= it.partner[2];
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic write_reg(logic [IW-1:0] idx, longint value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CW'(value);
        do @(negedge clk); while (!cfg_taken);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_box(longint lx, longint ux, longint ly, longint uy,
                           longint lz, longint uz, logic [2:0] pm);
        write_reg(REG_LOWER_X, lx);
        write_reg(REG_UPPER_X, ux);
        write_reg(REG_LOWER_Y, ly);
        write_reg(REG_UPPER_Y, uy);
        write_reg(REG_LOWER_Z, lz);
        write_reg(REG_UPPER_Z, uz);
        write_reg(REG_PERIODIC, longint'(pm));
    endtask

    task automatic drain_all();
        do @(negedge clk);
        while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0);
        repeat (40) @(negedge clk);
    endtask

    task automatic add_item(logic op, longint d, longint b, longint p);
        pos_item_t it;
        it.op = op;
        for (int a = 0; a < 3; a++)
        begin
            it.disp[a]    = CW'(d);
            it.base[a]    = CW'(b);
            it.partner[a] = CW'(p);
        end
        pending_items.push_back(it);
    endtask

    function automatic longint near_box(int a);
        longint e;
        e = box_hi[a] - box_lo[a];
        if (e <= 0 || e > 64'sd4294967296)
        begin
            e = 65536;
        end
        if ($urandom_range(9) == 0)
        begin
            return clamp_coord(($urandom_range(1) ? box_lo[a] : box_hi[a])
                               + $signed($urandom_range(2)) - 1);
        end
        return clamp_coord(box_lo[a] + longint'($urandom_range(7000)) * e / 1000 - 3 * e);
    endfunction

    function automatic longint any_coord();
        case ($urandom_range(3))
            0: return longint'($signed($urandom()));
            1: return longint'($signed($urandom_range(200000))) - 100000;
            2: return $urandom_range(1) ? C_MAX : C_MIN;
            default: return longint'($signed($urandom()));
        endcase
    endfunction

    task automatic add_random(int count);
        pos_item_t it;
        longint    x;
        longint    b;
        longint    e;
        for (int n = 0; n < count; n++)
        begin
            it.op = 1'($urandom_range(1));
            for (int a = 0; a < 3; a++)
            begin
                if ($urandom_range(99) < 70)
                begin
                    x = near_box(a);
                    b = $urandom_range(1) ? near_box(a) : any_coord();
                    e = box_hi[a] - box_lo[a];
                    if (e <= 0 || e > 64'sd4294967296)
                    begin
                        e = 65536;
                    end
                    it.base[a]    = CW'(b);
                    it.disp[a]    = CW'(clamp_coord(x - b));
                    it.partner[a] = CW'(clamp_coord(x + longint'($urandom_range(4000)) * e
                                                    / 1000 - 2 * e));
                end
                else
                begin
                    it.base[a]    = CW'(any_coord());
                    it.disp[a]    = CW'(any_coord());
                    it.partner[a] = CW'(any_coord());
                end
            end
            pending_items.push_back(it);
        end
    endtask

    initial
    begin
        longint lo;
        rst_n         = 1'b0;
        calm          = 1'b0;
        mismatches    = 0;
        item_ch.valid = 1'b0;
        item_ch.op    = 1'b0;
        item_ch.disp_x = '0;
        item_ch.disp_y = '0;
        item_ch.disp_z = '0;
        item_ch.base_x = '0;
        item_ch.base_y = '0;
        item_ch.base_z = '0;
        item_ch.partner_x = '0;
        item_ch.partner_y = '0;
        item_ch.partner_z = '0;
        res_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a] = 0;
            box_hi[a] = 65536;
        end
        periodic = 3'b000;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset box, nothing periodic: displacement passes through
        add_random(100);
        drain_all();

        set_box(0, 65536, 0, 65536, 0, 65536, 3'b111);
        add_item(OP_WRAP, 0, 0, 0);              // on lower face
        add_item(OP_WRAP, 65536, 0, 0);          // on upper face
        add_item(OP_WRAP, -1, 0, 0);
        add_item(OP_WRAP, 65537, 0, 0);
        add_item(OP_WRAP, -65536 * 7 - 5, 0, 123456); // far below, partner ignored
        add_item(OP_WRAP, 65536 * 9 + 3, 0, C_MIN);
        add_item(OP_WRAP, C_MAX, C_MAX, 0);      // saturating sums
        add_item(OP_WRAP, C_MIN, C_MIN, 0);
        add_item(OP_WRAP, C_MAX, C_MIN, C_MAX);
        add_item(~OP_WRAP, 32768, 0, 0);         // twice diff equals edge: no move
        add_item(~OP_WRAP, 32769, 0, 0);
        add_item(~OP_WRAP, -32768, 0, 0);
        add_item(~OP_WRAP, -32769, 0, 0);
        add_item(~OP_WRAP, C_MAX, C_MAX, C_MIN);
        add_item(~OP_WRAP, C_MIN, C_MIN, C_MAX);
        add_item(~OP_WRAP, C_MAX, 0, C_MIN);
        add_item(~OP_WRAP, 0, C_MIN, C_MAX);
        add_random(200);
        drain_all();

        // widest box on every axis
        set_box(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 3'b111);
        add_item(OP_WRAP, C_MAX, C_MAX, 0);
        add_item(~OP_WRAP, C_MAX, 0, C_MIN);
        add_item(~OP_WRAP, C_MIN, 0, C_MAX);
        add_random(200);
        drain_all();

        // inverted x, empty y, unit-lsb z
        set_box(1000, -1000, 500, 500, -7, -6, 3'b111);
        calm = 1'b1;
        add_random(200);
        drain_all();
        calm = 1'b0;

        set_box(C_MAX, C_MAX, -65536 * 3, 65536 * 5, C_MIN, C_MIN + 1, 3'b101);
        add_random(200);
        drain_all();

        for (int ph = 0; ph < 5; ph++)
        begin
            longint bx[6];
            for (int k = 0; k < 6; k += 2)
            begin
                lo = longint'($signed($urandom()));
                bx[k]   = lo;
                bx[k+1] = clamp_coord(($urandom_range(3) == 0)
                                      ? longint'($signed($urandom()))
                                      : lo + $urandom_range(1, 1 << 22));
            end
            set_box(bx[0], bx[1], bx[2], bx[3], bx[4], bx[5], 3'($urandom_range(7)));
            add_random(160);
            drain_all();
        end

        if (mismatches == 0)
        begin
            $display("tb_periodic_box_wrap_min_image: done, clean");
        end
        else
        begin
            $display("tb_periodic_box_wrap_min_image: done, errors");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb_periodic_box_wrap_min_image: done, errors");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/pbw_pkg.sv
rtl/core/pbw_if.sv
rtl/core/pbw_lane.sv
rtl/core/periodic_box_wrap_min_image.sv
tb/sv/tb_periodic_box_wrap_min_image.sv
